// ===== sv/kpt_pkg.sv =====
package kpt_pkg;

    typedef logic [7:0] t_byte;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_DEVICE_ID = 1'b0;

    localparam t_byte DEVICE_ID_RESET = 8'd192;
    localparam t_byte CAPS_KEY_CODE   = 8'h56;
    localparam t_byte CASE_OFFSET     = 8'd32;
    localparam t_byte LOWER_FIRST     = 8'h61;
    localparam t_byte LOWER_LAST      = 8'h7a;

    localparam logic [1:0] POS_SHIFT  = 2'd0;
    localparam logic [1:0] POS_DEVICE = 2'd1;
    localparam logic [1:0] POS_CODE   = 2'd2;
    localparam logic [1:0] POS_NULL   = 2'd3;

    typedef struct packed {
        logic  hit;
        t_byte ch;
    } t_xlat;

    typedef struct packed {
        logic [1:0] count;
        t_byte      char0;
        logic       last0;
        t_byte      char1;
        logic       caps_toggle;
    } t_judge;

    function automatic t_xlat xlat_lookup(input t_byte code);
        t_xlat r;
        r.hit = 1'b1;
        unique case (code)
            8'h24: r.ch = 8'd9;
            8'h25: r.ch = 8'd13;
            8'h27: r.ch = 8'd8;
            8'h30: r.ch = 8'd48;
            8'h31: r.ch = 8'd49;
            8'h32: r.ch = 8'd50;
            8'h33: r.ch = 8'd51;
            8'h34: r.ch = 8'd52;
            8'h35: r.ch = 8'd53;
            8'h36: r.ch = 8'd54;
            8'h37: r.ch = 8'd55;
            8'h38: r.ch = 8'd56;
            8'h39: r.ch = 8'd57;
            8'h50: r.ch = 8'd13;
            8'h54: r.ch = 8'd27;
            8'h55: r.ch = 8'd27;
            8'h58: r.ch = 8'd24;
            8'h70: r.ch = 8'd45;
            8'h71: r.ch = 8'd42;
            8'h72: r.ch = 8'd43;
            8'h73: r.ch = 8'd47;
            8'h74: r.ch = 8'd44;
            8'h75: r.ch = 8'd13;
            8'h76: r.ch = 8'd9;
            8'h77: r.ch = 8'd46;
            default: begin
                r.hit = 1'b0;
                r.ch  = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/kpt_judge.sv =====
module kpt_judge (
    input  logic           i_shift,
    input  kpt_pkg::t_byte i_device,
    input  kpt_pkg::t_byte i_code,
    input  logic           i_caps,
    input  kpt_pkg::t_byte i_dev_id,
    output kpt_pkg::t_judge o_judge
);
    import kpt_pkg::*;

    t_xlat w_xlat;
    logic  w_lower;

    assign w_xlat  = xlat_lookup(i_code);
    assign w_lower = i_caps && (i_code >= LOWER_FIRST) && (i_code <= LOWER_LAST);

    always_comb begin
        o_judge.count       = 2'd0;
        o_judge.char0       = i_code;
        o_judge.last0       = 1'b1;
        o_judge.char1       = i_code;
        o_judge.caps_toggle = 1'b0;
        priority if (i_device != i_dev_id) begin
            o_judge.count = 2'd0;
        end else if (!i_shift) begin
            o_judge.count = 2'd1;
            o_judge.char0 = w_lower ? (i_code - CASE_OFFSET) : i_code;
        end else if (i_code == CAPS_KEY_CODE) begin
            o_judge.caps_toggle = 1'b1;
        end else if (w_xlat.hit) begin
            o_judge.count = 2'd1;
            o_judge.char0 = w_xlat.ch;
        end else begin
            // Untranslated special key: zero lead-in, then the raw code.
            o_judge.count = 2'd2;
            o_judge.char0 = 8'd0;
            o_judge.last0 = 1'b0;
        end
    end

endmodule

// ===== sv/keycode_packet_translator_top.sv =====
// A result beat is offered from the result queue once the fourth byte of its packet has
// passed the input register and been judged with the registered shift, device and code.
// Throughput: one input byte per cycle while the result queue has room for its beats;
// a packet gives at most two result beats, held in a two-entry result queue.
// Reset: synchronous, active low; clears packet position, caps lock and the result queue,
// and sets the keyboard device id register to 192.
module keycode_packet_translator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpt_pkg::ADDR_W-1:0]    paddr,
    input  logic [kpt_pkg::DATA_W-1:0]    pwdata,
    output logic [kpt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  kpt_pkg::t_byte                i_rx_byte,
    output logic                          o_key_valid,
    input  logic                          i_key_ready,
    output kpt_pkg::t_byte                o_key_char,
    output logic                          o_last
);
    import kpt_pkg::*;

    t_byte      r_dev_id;
    logic       r_in_valid;
    t_byte      r_in_byte;
    logic [1:0] r_pos, n_pos;
    logic       r_shift, n_shift;
    t_byte      r_device, n_device;
    t_byte      r_code, n_code;
    logic       r_caps, n_caps;
    t_byte      r_q_char [2];
    t_byte      n_q_char [2];
    logic [1:0] r_q_last, n_q_last;
    logic [1:0] r_q_cnt, n_q_cnt;

    t_judge     w_judge;
    logic [1:0] w_need;
    logic       w_fits;
    logic       w_advance;
    logic       w_pop;
    logic       w_cfg_hit;

    kpt_judge u_judge (
        .i_shift  (r_shift),
        .i_device (r_device),
        .i_code   (r_code),
        .i_caps   (r_caps),
        .i_dev_id (r_dev_id),
        .o_judge  (w_judge)
    );

    assign w_cfg_hit = (paddr[ADDR_W-1:2] == REG_DEVICE_ID);
    assign pready    = 1'b1;
    assign prdata    = w_cfg_hit ? {{(DATA_W-8){1'b0}}, r_dev_id} : '0;

    assign w_need     = (r_pos == POS_NULL) ? w_judge.count : 2'd0;
    assign w_fits     = (w_need <= (2'd2 - r_q_cnt));
    assign w_advance  = r_in_valid && w_fits;
    assign o_rx_ready = !r_in_valid || w_fits;

    assign w_pop       = (r_q_cnt != 2'd0) && i_key_ready;
    assign o_key_valid = (r_q_cnt != 2'd0);
    assign o_key_char  = r_q_char[0];
    assign o_last      = r_q_last[0];

    always_comb begin
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_device = r_device;
        n_code   = r_code;
        n_caps   = r_caps;
        if (w_advance) begin
            n_pos = r_pos + 2'd1;
            unique case (r_pos)
                POS_SHIFT:  n_shift  = r_in_byte[7];
                POS_DEVICE: n_device = r_in_byte;
                POS_CODE:   n_code   = r_in_byte;
                POS_NULL:   n_caps   = r_caps ^ w_judge.caps_toggle;
            endcase
        end
    end

    always_comb begin
        n_q_char = r_q_char;
        n_q_last = r_q_last;
        n_q_cnt  = r_q_cnt;
        if (w_pop) begin
            n_q_char[0] = r_q_char[1];
            n_q_last[0] = r_q_last[1];
            n_q_cnt     = r_q_cnt - 2'd1;
        end
        if (w_advance && (w_need != 2'd0)) begin
            n_q_char[n_q_cnt[0]] = w_judge.char0;
            n_q_last[n_q_cnt[0]] = w_judge.last0;
            if (w_need == 2'd2) begin
                n_q_char[1] = w_judge.char1;
                n_q_last[1] = 1'b1;
            end
            n_q_cnt = n_q_cnt + w_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id   <= DEVICE_ID_RESET;
            r_in_valid <= 1'b0;
            r_pos      <= POS_SHIFT;
            r_shift    <= 1'b0;
            r_device   <= 8'd0;
            r_code     <= 8'd0;
            r_caps     <= 1'b0;
            r_q_cnt    <= 2'd0;
        end else begin
            if (psel && penable && pwrite && w_cfg_hit) begin
                r_dev_id <= pwdata[7:0];
            end
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_device <= n_device;
            r_code   <= n_code;
            r_caps   <= n_caps;
            r_q_cnt  <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        r_q_char <= n_q_char;
        r_q_last <= n_q_last;
    end

endmodule

// ===== sv/kpt_checker.sv =====
module kpt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [kpt_pkg::ADDR_W-1:0] paddr,
    input logic [kpt_pkg::DATA_W-1:0] pwdata,
    input logic [kpt_pkg::DATA_W-1:0] prdata,
    input logic                       pready,
    input logic                       i_rx_valid,
    input logic                       o_rx_ready,
    input kpt_pkg::t_byte             i_rx_byte,
    input logic                       o_key_valid,
    input logic                       i_key_ready,
    input kpt_pkg::t_byte             o_key_char,
    input logic                       o_last
);
    import kpt_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_valid && !i_key_ready |=> o_key_valid && $stable(o_key_char) && $stable(o_last))
        else $error("result beat changed while stalled");

    // Only the extended lead-in is a non-final beat, and it always carries zero.
    a_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_valid && !o_last |-> o_key_char == 8'd0)
        else $error("non-final beat is not a zero lead-in");

    // The raw code follows its lead-in in the very next cycle.
    a_lead_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_valid && i_key_ready && !o_last |=> o_key_valid && o_last)
        else $error("lead-in not followed by final beat");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_key_valid)
        else $error("result offered right after reset");

endmodule

bind keycode_packet_translator_top kpt_checker u_kpt_checker (.*);
